[design/bts_pkg.sv]
// Shared types and constants for the best threshold split search block.
package bts_pkg;

  localparam int FEAT_W_MAX = 24;
  localparam int CNT_W_MAX  = 33;
  localparam int PROD_W     = 96;

  localparam logic [1:0] REG_PENALTY   = 2'd0;
  localparam logic [1:0] REG_NEG_TOTAL = 2'd1;
  localparam logic [1:0] REG_POS_TOTAL = 2'd2;

  localparam logic [23:0] PENALTY_RESET = 24'd65536;

  // One boundary to be scored in both directions.
  typedef struct packed {
    logic [FEAT_W_MAX-1:0] feat;
    logic [31:0]           thr;
    logic [23:0]           weight;
    logic [CNT_W_MAX-1:0]  negs;
    logic [CNT_W_MAX-1:0]  poss;
    logic                  end_all;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CNT,
    B_MULP,
    B_DIFF,
    B_LO,
    B_HI,
    B_SAT,
    B_OFFER,
    B_EMIT
  } back_state_t;

endpackage

[design/bts_fifo.sv]
// Two-entry queue of boundary jobs between front and back.
module bts_fifo
  import bts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/bts_front.sv]
// Front end: accepts examples, keeps running counts and raises boundary jobs.
module bts_front
  import bts_pkg::*;
#(
  parameter int FEATURE_BITS = 16,
  parameter int COUNT_BITS   = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] feature_index,
  input  logic [31:0] sample_value,
  input  logic        label,
  input  logic [23:0] feat_weight,
  input  logic        last_of_feature,
  input  logic        last_of_all,
  output logic        push,
  output job_t        push_job,
  input  logic        fifo_full
);

  localparam int CW = COUNT_BITS + 1;
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic [31:0]   prev_value;
  logic          have_prev;
  logic [CW-1:0] neg_run;
  logic [CW-1:0] pos_run;
  logic          pend_a;
  logic          pend_b;
  job_t          job_a;
  job_t          job_b;

  logic          accept;
  logic [CW-1:0] neg_inc;
  logic [CW-1:0] pos_inc;
  logic [FEAT_W_MAX-1:0] feat_w;
  logic          ends;

  assign in_stall = pend_a | pend_b;
  assign accept   = in_valid && !in_stall;
  assign push     = pend_a | pend_b;
  assign push_job = pend_a ? job_a : job_b;

  assign feat_w  = FEAT_W_MAX'(FEATURE_BITS'(feature_index));
  assign ends    = last_of_feature | last_of_all;
  assign neg_inc = (!label && neg_run != CNT_MAX) ? neg_run + 1'b1 : neg_run;
  assign pos_inc = (label && pos_run != CNT_MAX) ? pos_run + 1'b1 : pos_run;

  always_ff @(posedge clk) begin
    if (accept) begin
      job_a.feat    <= feat_w;
      job_a.thr     <= prev_value;
      job_a.weight  <= feat_weight;
      job_a.negs    <= CNT_W_MAX'(neg_run);
      job_a.poss    <= CNT_W_MAX'(pos_run);
      job_a.end_all <= 1'b0;
      job_b.feat    <= feat_w;
      job_b.thr     <= sample_value;
      job_b.weight  <= feat_weight;
      job_b.negs    <= CNT_W_MAX'(neg_inc);
      job_b.poss    <= CNT_W_MAX'(pos_inc);
      job_b.end_all <= last_of_all;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_value <= '0;
      have_prev  <= 1'b0;
      neg_run    <= '0;
      pos_run    <= '0;
      pend_a     <= 1'b0;
      pend_b     <= 1'b0;
    end else if (accept) begin
      pend_a <= have_prev && (sample_value != prev_value);
      pend_b <= ends;
      if (ends) begin
        prev_value <= '0;
        have_prev  <= 1'b0;
        neg_run    <= '0;
        pos_run    <= '0;
      end else begin
        prev_value <= sample_value;
        have_prev  <= 1'b1;
        neg_run    <= neg_inc;
        pos_run    <= pos_inc;
      end
    end else if (push && !fifo_full) begin
      if (pend_a) pend_a <= 1'b0;
      else        pend_b <= 1'b0;
    end
  end

endmodule

[design/bts_back.sv]
// Back end: scores each boundary both ways, keeps the tie list, emits it.
module bts_back
  import bts_pkg::*;
#(
  parameter int MAX_TIES     = 16,
  parameter int COUNT_BITS   = 20,
  parameter int FEATURE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [23:0]         penalty_p,
  input  logic [COUNT_BITS:0] negative_total,
  input  logic [COUNT_BITS:0] positive_total,
  input  logic                fifo_empty,
  input  job_t                pop_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         split_feature,
  output logic [31:0]         split_threshold,
  output logic                direction,
  output logic [20:0]         negatives_counted,
  output logic [20:0]         positives_counted,
  output logic [63:0]         score,
  output logic                ties_overflowed,
  output logic                no_solution,
  output logic                last
);

  localparam int CW   = COUNT_BITS + 1;
  localparam int DW   = CW + 24;
  localparam int HALF = (DW + 1) / 2;
  localparam int HW   = DW - HALF;
  localparam int TW   = $clog2(MAX_TIES + 1);
  localparam int IW   = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
  localparam logic [TW-1:0] TIES_CAP = TW'(MAX_TIES);
  localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  back_state_t state, state_next;

  job_t            job;
  logic            dir;
  logic [CW-1:0]   n_cnt;
  logic [CW-1:0]   p_cnt;
  logic [DW:0]     nq;
  logic [DW:0]     pq;
  logic [DW-1:0]   mag;
  logic            neg;
  logic [HALF+23:0] lo;
  logic [HW+23:0]  hi;
  logic [63:0]     cand;
  logic [63:0]     best_score;
  logic [TW-1:0]   tie_total;
  logic            overflow_seen;
  logic [TW-1:0]   emit_idx;

  logic [FEATURE_BITS-1:0] tie_feat [MAX_TIES];
  logic [31:0]             tie_thr  [MAX_TIES];
  logic                    tie_dir  [MAX_TIES];
  logic [CW-1:0]           tie_negs [MAX_TIES];
  logic [CW-1:0]           tie_poss [MAX_TIES];

  logic [CW-1:0]   run_n, run_p, sel_n, sel_p;
  logic [DW:0]     diff;
  logic [DW-1:0]   pprod;
  logic [PROD_W-1:0] full;
  logic            big;
  logic            better, equal;
  logic            emit_go, emit_final;
  logic [IW-1:0]   rd_idx;

  assign run_n = CW'(job.negs);
  assign run_p = CW'(job.poss);
  always_comb begin
    if (!dir) begin
      sel_n = run_n;
      sel_p = run_p;
    end else begin
      sel_n = (negative_total > run_n) ? negative_total - run_n : '0;
      sel_p = (positive_total > run_p) ? positive_total - run_p : '0;
    end
  end

  // full-width penalty product, 24 x CW bits
  assign pprod  = penalty_p * p_cnt;
  assign diff   = nq - pq;
  assign full   = PROD_W'(lo) + (PROD_W'(hi) << HALF);
  assign big    = |full[PROD_W-1:63];
  assign better = $signed(cand) > $signed(best_score);
  assign equal  = cand == best_score;
  assign rd_idx = emit_idx[IW-1:0];
  assign emit_final = (tie_total == '0) || (emit_idx + 1'b1 == tie_total);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!fifo_empty) state_next = B_CNT;
      B_CNT:   state_next = B_MULP;
      B_MULP:  state_next = B_DIFF;
      B_DIFF:  state_next = B_LO;
      B_LO:    state_next = B_HI;
      B_HI:    state_next = B_SAT;
      B_SAT:   state_next = B_OFFER;
      B_OFFER: begin
        if (!dir)              state_next = B_CNT;
        else if (job.end_all)  state_next = B_EMIT;
        else                   state_next = B_IDLE;
      end
      B_EMIT:  if (emit_go && emit_final) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop     = 1'b0;
    emit_go = 1'b0;
    case (state)
      B_IDLE:  pop = !fifo_empty;
      B_EMIT:  emit_go = !out_valid || !out_stall;
      default: begin
        pop     = 1'b0;
        emit_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE:  if (pop) job <= pop_job;
      B_CNT: begin
        n_cnt <= sel_n;
        p_cnt <= sel_p;
      end
      B_MULP: begin
        nq <= (DW + 1)'(n_cnt) << 16;
        pq <= {1'b0, pprod};
      end
      B_DIFF: begin
        neg <= diff[DW];
        mag <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
      end
      B_LO:    lo <= mag[HALF-1:0] * job.weight;
      B_HI:    hi <= mag[DW-1:HALF] * job.weight;
      B_SAT: begin
        if (neg) cand <= big ? S_MIN : -full[63:0];
        else     cand <= big ? S_MAX : full[63:0];
      end
      default: cand <= cand;
    endcase
  end

  // tie list entries
  always_ff @(posedge clk) begin
    if (state == B_OFFER && (better || (equal && tie_total < TIES_CAP))) begin
      tie_feat[better ? '0 : tie_total[IW-1:0]] <= FEATURE_BITS'(job.feat);
      tie_thr [better ? '0 : tie_total[IW-1:0]] <= job.thr;
      tie_dir [better ? '0 : tie_total[IW-1:0]] <= dir;
      tie_negs[better ? '0 : tie_total[IW-1:0]] <= n_cnt;
      tie_poss[better ? '0 : tie_total[IW-1:0]] <= p_cnt;
    end
  end

  // search state, direction and emit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      dir           <= 1'b0;
      best_score    <= S_MIN;
      tie_total     <= '0;
      overflow_seen <= 1'b0;
      emit_idx      <= '0;
    end else begin
      case (state)
        B_IDLE: dir <= 1'b0;
        B_OFFER: begin
          dir <= ~dir;
          if (better) begin
            best_score    <= cand;
            tie_total     <= TW'(1);
            overflow_seen <= 1'b0;
          end else if (equal) begin
            if (tie_total < TIES_CAP) tie_total <= tie_total + 1'b1;
            else                      overflow_seen <= 1'b1;
          end
        end
        B_EMIT: begin
          if (emit_go) begin
            if (emit_final) begin
              emit_idx      <= '0;
              best_score    <= S_MIN;
              tie_total     <= '0;
              overflow_seen <= 1'b0;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: dir <= dir;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (tie_total == '0) begin
        split_feature     <= '0;
        split_threshold   <= '0;
        direction         <= 1'b0;
        negatives_counted <= '0;
        positives_counted <= '0;
        score             <= '0;
        ties_overflowed   <= 1'b0;
        no_solution       <= 1'b1;
        last              <= 1'b1;
      end else begin
        split_feature     <= 16'(tie_feat[rd_idx]);
        split_threshold   <= tie_thr[rd_idx];
        direction         <= tie_dir[rd_idx];
        negatives_counted <= 21'(tie_negs[rd_idx]);
        positives_counted <= 21'(tie_poss[rd_idx]);
        score             <= best_score;
        ties_overflowed   <= overflow_seen;
        no_solution       <= 1'b0;
        last              <= emit_final;
      end
    end
  end

endmodule

[design/best_threshold_split_search.sv]
// Top level of the best threshold split search block.
//
// Input channel (in_valid / in_stall): one example per transfer, features in
// turn, values ascending within a feature, with end-of-feature and end-of-run
// marks. Output channel (out_valid / out_stall): the tied best splits, sent
// only after the end-of-run example, the final one flagged by last; an empty
// run gives a single no_solution result.
// Configuration: cfg_write / cfg_index / cfg_data, written while idle.
// The front takes an example and raises up to two boundary jobs, one per
// cycle while there is room, into a two-entry queue; it stalls its input
// while jobs wait. The back takes each job from the queue and scores it in
// both directions, each by count select, penalty product, difference, two
// half-width weight products, saturation and tie update. The first result
// leaves once the end-of-run boundary and every job ahead of it are scored;
// the rest follow one per cycle while the output is not stalled, up to
// MAX_TIES results.
// A stall on the output holds the result register and the back; the front
// keeps filling the queue until it is full.
// Reset (rst, synchronous) restores penalty 1.0, zero totals, an empty tie
// list and the lowest best score.
module best_threshold_split_search
  import bts_pkg::*;
#(
  parameter int MAX_TIES     = 16,
  parameter int COUNT_BITS   = 20,
  parameter int FEATURE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] feature_index,
  input  logic [31:0] sample_value,
  input  logic        label,
  input  logic [23:0] feat_weight,
  input  logic        last_of_feature,
  input  logic        last_of_all,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] split_feature,
  output logic [31:0] split_threshold,
  output logic        direction,
  output logic [20:0] negatives_counted,
  output logic [20:0] positives_counted,
  output logic [63:0] score,
  output logic        ties_overflowed,
  output logic        no_solution,
  output logic        last
);

  logic [23:0]         penalty_p;
  logic [COUNT_BITS:0] negative_total;
  logic [COUNT_BITS:0] positive_total;

  logic push, fifo_full, pop, fifo_empty;
  job_t push_job, pop_job;

  // configuration registers; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_p      <= PENALTY_RESET;
      negative_total <= '0;
      positive_total <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PENALTY:   penalty_p      <= cfg_data;
        REG_NEG_TOTAL: negative_total <= (COUNT_BITS + 1)'(cfg_data);
        REG_POS_TOTAL: positive_total <= (COUNT_BITS + 1)'(cfg_data);
        default:       penalty_p      <= penalty_p;
      endcase
    end
  end

  bts_front #(
    .FEATURE_BITS(FEATURE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .feature_index  (feature_index),
    .sample_value   (sample_value),
    .label          (label),
    .feat_weight    (feat_weight),
    .last_of_feature(last_of_feature),
    .last_of_all    (last_of_all),
    .push           (push),
    .push_job       (push_job),
    .fifo_full      (fifo_full)
  );

  bts_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (fifo_full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (fifo_empty)
  );

  bts_back #(
    .MAX_TIES    (MAX_TIES),
    .COUNT_BITS  (COUNT_BITS),
    .FEATURE_BITS(FEATURE_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .penalty_p        (penalty_p),
    .negative_total   (negative_total),
    .positive_total   (positive_total),
    .fifo_empty       (fifo_empty),
    .pop_job          (pop_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .split_feature    (split_feature),
    .split_threshold  (split_threshold),
    .direction        (direction),
    .negatives_counted(negatives_counted),
    .positives_counted(positives_counted),
    .score            (score),
    .ties_overflowed  (ties_overflowed),
    .no_solution      (no_solution),
    .last             (last)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the best threshold split search block.
module testbench;
  import bts_pkg::*;

  localparam int TIE_LIMIT = 16;
  localparam logic [63:0] CNT_CEIL = (64'd1 << 21) - 1;
  localparam int IDLE_LIMIT = 20000;

  // One example as offered on the input channel.
  typedef struct packed {
    logic [15:0] feat;
    logic [31:0] val;
    logic        lab;
    logic [23:0] wgt;
    logic        eof;
    logic        eor;
  } example_t;

  // One split as expected on the output channel.
  typedef struct packed {
    logic [15:0] feat;
    logic [31:0] thr;
    logic        dir;
    logic [20:0] negs;
    logic [20:0] poss;
    logic [63:0] scr;
    logic        ovf;
    logic        nosol;
    logic        lst;
  } split_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_PENALTY;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] feature_index = '0;
  logic [31:0] sample_value = '0;
  logic        label = 1'b0;
  logic [23:0] feat_weight = '0;
  logic        last_of_feature = 1'b0;
  logic        last_of_all = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] split_feature;
  logic [31:0] split_threshold;
  logic        direction;
  logic [20:0] negatives_counted;
  logic [20:0] positives_counted;
  logic [63:0] score;
  logic        ties_overflowed;
  logic        no_solution;
  logic        last;

  best_threshold_split_search dut (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic [63:0] pen_p, neg_tot, pos_tot;
  logic [31:0] prev_val;
  logic        have_prev;
  logic [63:0] neg_run, pos_run;
  logic signed [63:0] best;
  int          tie_cnt;
  logic        ovf_seen;
  split_t      tie_list [TIE_LIMIT];

  example_t    pending_examples [$];
  split_t      expected_splits [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          quiet_phase = 0;
  bit          hold_req = 0;

  task automatic clear_search();
    prev_val = '0; have_prev = 0; neg_run = '0; pos_run = '0;
    best = 64'sh8000_0000_0000_0000; tie_cnt = 0; ovf_seen = 0;
  endtask

  // Exact Q.32 utility, saturated to 64 bits.
  function automatic logic signed [63:0] utility(logic [63:0] n, logic [63:0] pc,
                                                 logic [23:0] w);
    logic signed [127:0] d, prod;
    d = $signed({64'd0, n << 16}) - $signed({64'd0, pen_p * pc});
    prod = d * $signed({104'd0, w});
    if (prod > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (prod < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return prod[63:0];
  endfunction

  task automatic offer_split(logic signed [63:0] s, logic [15:0] f, logic [31:0] t,
                             logic d, logic [63:0] n, logic [63:0] pc);
    if (s > best) begin
      best = s; tie_cnt = 0; ovf_seen = 0;
    end else if (s != best) begin
      return;
    end
    if (tie_cnt < TIE_LIMIT) begin
      tie_list[tie_cnt] = '{feat: f, thr: t, dir: d, negs: n[20:0], poss: pc[20:0],
                            scr: '0, ovf: 0, nosol: 0, lst: 0};
      tie_cnt++;
    end else begin
      ovf_seen = 1;
    end
  endtask

  task automatic score_boundary(logic [15:0] f, logic [31:0] t, logic [23:0] w);
    logic [63:0] n1, p1;
    n1 = neg_tot > neg_run ? neg_tot - neg_run : 0;
    p1 = pos_tot > pos_run ? pos_tot - pos_run : 0;
    offer_split(utility(neg_run, pos_run, w), f, t, 1'b0, neg_run, pos_run);
    offer_split(utility(n1, p1, w), f, t, 1'b1, n1, p1);
  endtask

  // Advance the predictor by one accepted example.
  task automatic predict_example(example_t e);
    split_t r;
    if (have_prev && e.val != prev_val) score_boundary(e.feat, prev_val, e.wgt);
    if (e.lab) begin
      if (pos_run < CNT_CEIL) pos_run++;
    end else begin
      if (neg_run < CNT_CEIL) neg_run++;
    end
    prev_val = e.val; have_prev = 1;
    if (e.eof || e.eor) begin
      score_boundary(e.feat, e.val, e.wgt);
      neg_run = 0; pos_run = 0; have_prev = 0; prev_val = 0;
    end
    if (!e.eor) return;
    if (tie_cnt == 0) begin
      r = '0; r.nosol = 1; r.lst = 1;
      expected_splits.push_back(r);
    end else begin
      for (int k = 0; k < tie_cnt; k++) begin
        r = tie_list[k];
        r.scr = best; r.ovf = ovf_seen; r.lst = (k + 1 == tie_cnt);
        expected_splits.push_back(r);
      end
    end
    clear_search();
  endtask

  // Transfer seen at the last rising edge.
  bit took;
  always @(posedge clk) begin
    took <= in_valid && !in_stall && !rst;
  end

  // Driver: items change at the falling edge; a stalled item is held.
  int tx_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || took) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_examples.size() > 0) begin
          example_t e;
          e = pending_examples.pop_front();
          predict_example(e);
          feature_index <= e.feat; sample_value <= e.val; label <= e.lab;
          feat_weight <= e.wgt; last_of_feature <= e.eof; last_of_all <= e.eor;
          in_valid <= 1'b1;
          if (!quiet_phase && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random bursts, plus one long hold-off counted here.
  int rx_gap = 0;
  int hold_off = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_off <= 399;
        out_stall <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each transfer with the oldest expected split.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        split_t got, exp_s;
        got = '{split_feature, split_threshold, direction, negatives_counted,
                positives_counted, score, ties_overflowed, no_solution, last};
        if (expected_splits.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", got);
        end else begin
          exp_s = expected_splits.pop_front();
          if (got !== exp_s) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %h got %h", exp_s, got);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] v);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PENALTY:   pen_p = v;
      REG_NEG_TOTAL: neg_tot = v & CNT_CEIL;
      REG_POS_TOTAL: pos_tot = v & CNT_CEIL;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_examples.size() > 0 || in_valid || expected_splits.size() > 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // One run: a few features of sorted values, ending with the end-of-run mark.
  task automatic queue_run(int nfeat, int maxlen, bit tiny_vals);
    example_t e;
    int len, v;
    for (int f = 0; f < nfeat; f++) begin
      len = $urandom_range(1, maxlen);
      v = $urandom;
      e.feat = 16'($urandom);
      e.wgt = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
      for (int i = 0; i < len; i++) begin
        e.val = v;
        if ($urandom_range(0, 2) != 0) v = v + (tiny_vals ? 1 : $urandom_range(1, 1000));
        e.lab = 1'($urandom); e.eof = (i == len - 1); e.eor = 0;
        if ($urandom_range(0, 15) == 0) e.eof = 0;
        if (f == nfeat - 1 && i == len - 1) e.eor = 1;
        pending_examples.push_back(e);
      end
    end
  endtask

  int issued;
  initial begin
    pen_p = 64'(PENALTY_RESET); neg_tot = 0; pos_tot = 0;
    clear_search();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty totals, extreme fields, most negative score tie.
    write_reg(REG_NEG_TOTAL, 24'd3);
    write_reg(REG_POS_TOTAL, 24'd2);
    pending_examples.push_back('{16'hFFFF, 32'h8000_0000, 1'b1, 24'hFFFFFF, 1'b0, 1'b0});
    pending_examples.push_back('{16'hFFFF, 32'h8000_0000, 1'b0, 24'hFFFFFF, 1'b0, 1'b0});
    pending_examples.push_back('{16'hFFFF, 32'h7FFF_FFFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b0});
    pending_examples.push_back('{16'h0000, 32'h0, 1'b0, 24'h0, 1'b0, 1'b0});
    pending_examples.push_back('{16'h0001, 32'h1, 1'b0, 24'h0, 1'b0, 1'b1});
    pending_examples.push_back('{16'h0, 32'h5, 1'b1, 24'h0, 1'b0, 1'b1});
    wait_drained();
    write_reg(REG_PENALTY, 24'hFFFFFF);
    write_reg(REG_NEG_TOTAL, 24'h1FFFFF);
    write_reg(REG_POS_TOTAL, 24'h0);
    pending_examples.push_back('{16'h1234, 32'hFFFF_FFFF, 1'b0, 24'hFFFFFF, 1'b1, 1'b0});
    pending_examples.push_back('{16'h4321, 32'h0, 1'b1, 24'hFFFFFF, 1'b0, 1'b1});
    // Many equal zero scores: tie list fills and overflows.
    for (int i = 0; i < 12; i++)
      pending_examples.push_back('{16'(i), 32'(i), 1'b0, 24'h0, 1'b1, i == 11});
    wait_drained();

    // Random phases with varied register settings.
    issued = 0;
    while (issued < 480) begin
      write_reg(REG_PENALTY,
                24'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 24'h3FFFF)));
      write_reg(REG_NEG_TOTAL, 24'($urandom_range(0, 40)));
      write_reg(REG_POS_TOTAL, 24'($urandom_range(0, 40)));
      for (int r = 0; r < 4; r++) queue_run($urandom_range(1, 4), 8, 1'($urandom));
      if (!hold_req && issued > 120) hold_req = 1;
      if (issued > 400) quiet_phase = 1;
      issued += pending_examples.size();
      // Sender pauses here until every expected result has come.
      wait_drained();
    end
    if (mismatches == 0 && expected_splits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
